// File: hw/rtl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants and types for the deframer and its CRC-16 byte unit.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CRC_W-1:0]  crc_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_BODY = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_BODY      = 3'd1,
    ST_GOOD      = 3'd2,
    ST_BAD_TOKEN = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_CRC_ERR   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_START_BYTE = 2'd0,
    REG_TOKEN_BYTE = 2'd1,
    REG_MAX_LEN    = 2'd2
  } reg_idx_t;

endpackage

// File: hw/rtl/sfd_crc16.sv
// ---------------------------------------------------------------------------
// CRC-16 byte update
// Advances a reflected CRC-16 by one byte, least significant bit first.
// ---------------------------------------------------------------------------
module sfd_crc16 (
  input  sfd_pkg::crc_t  crc_i,
  input  sfd_pkg::byte_t data_i,
  output sfd_pkg::crc_t  crc_o
);
  import sfd_pkg::*;

  always_comb begin
    crc_t c;
    c = crc_i ^ {{(CRC_W-BYTE_W){1'b0}}, data_i};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// File: hw/rtl/serial_frame_deframer_crc16.sv
// The result beat of an accepted input beat is registered; it shows in the next cycle.
// Throughput: one beat per cycle; the result register frees itself in the
// cycle it is taken, so the input stalls only while a result waits unread.
// Reset (synchronous, active low) returns the deframer to hunting, sets the
// CRC to all ones and loads the registers with their default values.
// ---------------------------------------------------------------------------
// Serial frame deframer with CRC-16 check
// Hunts for a start byte, parses the header, streams the body and checks the
// CRC; every received byte yields exactly one result beat.
// ---------------------------------------------------------------------------
module serial_frame_deframer_crc16 #(
  parameter int BODY_MAX = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [9:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sfd_pkg::byte_t       in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [7:0]           out_data_byte,
  output logic [8:0]           out_body_index,
  output logic [15:0]          out_seq_number,
  output logic [9:0]           out_body_len
);
  import sfd_pkg::*;

  localparam logic [31:0] BODY_MAX_W = 32'(BODY_MAX);

  byte_t       start_byte_r;
  byte_t       token_byte_r;
  logic [9:0]  max_len_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] length_r, length_nxt;
  logic [9:0]  body_cnt_r, body_cnt_nxt;
  crc_t        crc_r, crc_nxt;

  logic        out_valid_r;
  status_t     status_r, status_nxt;
  byte_t       data_r, data_nxt;
  logic [8:0]  index_r, index_nxt;
  logic [15:0] seq_out_r, seq_out_nxt;
  logic [9:0]  len_out_r, len_out_nxt;

  logic        in_acc;
  crc_t        crc_in, crc_upd;
  logic [31:0] lim;
  logic [9:0]  body_cnt_inc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'd27;
      token_byte_r <= 8'd14;
      max_len_r    <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE: start_byte_r <= cfg_wdata[7:0];
        REG_TOKEN_BYTE: token_byte_r <= cfg_wdata[7:0];
        REG_MAX_LEN:    max_len_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign crc_in = (phase_r == PH_HUNT) ? CRC_INIT : crc_r;

  sfd_crc16 u_crc (
    .crc_i  (crc_in),
    .data_i (in_rx_byte),
    .crc_o  (crc_upd)
  );

  assign lim = ({22'd0, max_len_r} > BODY_MAX_W) ? BODY_MAX_W : {22'd0, max_len_r};
  assign body_cnt_inc = body_cnt_r + 10'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    seq_nxt      = seq_r;
    length_nxt   = length_r;
    body_cnt_nxt = body_cnt_r;
    crc_nxt      = crc_r;
    status_nxt   = ST_NONE;
    data_nxt     = '0;
    index_nxt    = '0;
    case (phase_r)
      PH_HUNT: begin
        if (in_rx_byte == start_byte_r) begin
          crc_nxt      = crc_upd;
          hdr_cnt_nxt  = '0;
          seq_nxt      = '0;
          length_nxt   = '0;
          body_cnt_nxt = '0;
          phase_nxt    = PH_HEAD;
        end
      end
      PH_HEAD: begin
        crc_nxt = crc_upd;
        case (hdr_cnt_r)
          3'd0:    seq_nxt[7:0]      = in_rx_byte;
          3'd1:    seq_nxt[15:8]     = in_rx_byte;
          3'd2:    length_nxt[7:0]   = in_rx_byte;
          3'd3:    length_nxt[15:8]  = in_rx_byte;
          3'd4:    length_nxt[23:16] = in_rx_byte;
          3'd5:    length_nxt[31:24] = in_rx_byte;
          default: ;
        endcase
        if (hdr_cnt_r >= 3'd6) begin
          if (in_rx_byte != token_byte_r) begin
            status_nxt = ST_BAD_TOKEN;
            phase_nxt  = PH_HUNT;
          end else if (length_r > lim) begin
            status_nxt = ST_TOO_LONG;
            phase_nxt  = PH_HUNT;
          end else begin
            body_cnt_nxt = '0;
            hdr_cnt_nxt  = '0;
            phase_nxt    = (length_r == '0) ? PH_CRC : PH_BODY;
          end
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        end
      end
      PH_BODY: begin
        crc_nxt      = crc_upd;
        status_nxt   = ST_BODY;
        data_nxt     = in_rx_byte;
        index_nxt    = body_cnt_r[8:0];
        body_cnt_nxt = body_cnt_inc;
        if ({22'd0, body_cnt_inc} >= length_r) begin
          hdr_cnt_nxt = '0;
          phase_nxt   = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_nxt = crc_upd;
        if (hdr_cnt_r == 3'd0) begin
          hdr_cnt_nxt = 3'd1;
        end else begin
          status_nxt  = (crc_upd == '0) ? ST_GOOD : ST_CRC_ERR;
          hdr_cnt_nxt = '0;
          phase_nxt   = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    if (status_nxt != ST_NONE) begin
      seq_out_nxt = seq_nxt;
      len_out_nxt = (|length_nxt[31:10]) ? 10'h3FF : length_nxt[9:0];
    end else begin
      seq_out_nxt = '0;
      len_out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      hdr_cnt_r  <= '0;
      seq_r      <= '0;
      length_r   <= '0;
      body_cnt_r <= '0;
      crc_r      <= CRC_INIT;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      seq_r      <= seq_nxt;
      length_r   <= length_nxt;
      body_cnt_r <= body_cnt_nxt;
      crc_r      <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= status_nxt;
      data_r    <= data_nxt;
      index_r   <= index_nxt;
      seq_out_r <= seq_out_nxt;
      len_out_r <= len_out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_data_byte  = data_r;
  assign out_body_index = index_r;
  assign out_seq_number = seq_out_r;
  assign out_body_len   = len_out_r;

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted input beat produced no result beat");

  a_body_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> ({22'd0, body_cnt_r} < length_r))
    else $error("body count reached the length while still in the body");

  a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEAD) |-> (hdr_cnt_r <= 3'd6))
    else $error("header count ran past the token byte");

endmodule

// File: tb/serial_frame_deframer_crc16_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Serial frame deframer testbench
// Feeds received bytes, both well-formed frames and broken ones, into the
// deframer. A local model of the frame parser and its CRC-16 predicts one
// result beat per byte, and every result beat is checked field by field.
// ---------------------------------------------------------------------------
module serial_frame_deframer_crc16_tb;
  import sfd_pkg::*;

  localparam int BODY_MAX = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 13;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic [8:0]  index;
    logic [15:0] seq;
    logic [9:0]  len;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_START_BYTE;
  logic [9:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  byte_t       in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_data_byte;
  logic [8:0]  out_body_index;
  logic [15:0] out_seq_number;
  logic [9:0]  out_body_len;

  serial_frame_deframer_crc16 #(.BODY_MAX(BODY_MAX)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_data_byte (out_data_byte),
    .out_body_index(out_body_index),
    .out_seq_number(out_seq_number),
    .out_body_len  (out_body_len)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies and parser state of the model.
  byte_t       cfg_start = 8'd27;
  byte_t       cfg_token = 8'd14;
  logic [9:0]  cfg_max = 10'd512;
  phase_t      rx_phase = PH_HUNT;
  int unsigned hdr_count = 0;
  logic [15:0] seq_acc = '0;
  logic [31:0] len_acc = '0;
  logic [9:0]  body_count = '0;
  crc_t        crc_acc = CRC_INIT;

  frame_result_t pending_results[$];
  int            mismatches = 0;
  int            cycles = 0;
  int            frame_bytes = 0;
  bit            no_idle = 1'b0;

  function automatic crc_t crc_next(crc_t c, byte_t b);
    crc_t r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] len_limit();
    return (cfg_max > BODY_MAX) ? BODY_MAX : cfg_max;
  endfunction

  task automatic deframe_byte(input byte_t b);
    frame_result_t r;
    r = '0;
    r.status = ST_NONE;
    case (rx_phase)
      PH_HUNT: begin
        if (b == cfg_start) begin
          crc_acc = crc_next(CRC_INIT, b);
          hdr_count = 0;
          seq_acc = '0;
          len_acc = '0;
          body_count = '0;
          rx_phase = PH_HEAD;
        end
      end
      PH_HEAD: begin
        crc_acc = crc_next(crc_acc, b);
        if (hdr_count < 2) begin
          seq_acc = seq_acc | (16'(b) << (8 * hdr_count));
        end else if (hdr_count < 6) begin
          len_acc = len_acc | (32'(b) << (8 * (hdr_count - 2)));
        end
        if (hdr_count >= 6) begin
          if (b != cfg_token) begin
            r.status = ST_BAD_TOKEN;
            rx_phase = PH_HUNT;
          end else if (len_acc > len_limit()) begin
            r.status = ST_TOO_LONG;
            rx_phase = PH_HUNT;
          end else begin
            body_count = '0;
            hdr_count = 0;
            rx_phase = (len_acc == 0) ? PH_CRC : PH_BODY;
          end
        end else begin
          hdr_count++;
        end
      end
      PH_BODY: begin
        crc_acc = crc_next(crc_acc, b);
        r.status = ST_BODY;
        r.data = b;
        r.index = body_count[8:0];
        body_count = body_count + 10'd1;
        if ({22'b0, body_count} >= len_acc) begin
          hdr_count = 0;
          rx_phase = PH_CRC;
        end
      end
      default: begin
        crc_acc = crc_next(crc_acc, b);
        if (hdr_count == 0) begin
          hdr_count = 1;
        end else begin
          r.status = (crc_acc == 0) ? ST_GOOD : ST_CRC_ERR;
          hdr_count = 0;
          rx_phase = PH_HUNT;
        end
      end
    endcase
    if (r.status != ST_NONE) begin
      r.seq = seq_acc;
      r.len = (len_acc > 32'd1023) ? 10'd1023 : len_acc[9:0];
    end
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL serial_frame_deframer_crc16");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, status %0d", out_status));
      end else begin
        want = pending_results.pop_front();
        check_field("status", out_status, want.status);
        check_field("data_byte", out_data_byte, want.data);
        check_field("body_index", out_body_index, want.index);
        check_field("seq_number", out_seq_number, want.seq);
        check_field("body_len", out_body_len, want.len);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_byte(input byte_t b);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    deframe_byte(b);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_BYTE: cfg_start = data[7:0];
      REG_TOKEN_BYTE: cfg_token = data[7:0];
      REG_MAX_LEN:    cfg_max = data;
      default: ;
    endcase
  endtask

  // Sends at most cut bytes of the frame; a negative cut sends it whole.
  // The body and CRC bytes follow only when the header will be accepted.
  task automatic send_frame(input logic [15:0] seq, input logic [31:0] len,
                            input byte_t tok, input bit bad_crc, input int cut);
    byte_t bytes[$];
    crc_t  c;
    int    n;
    bytes.push_back(cfg_start);
    bytes.push_back(seq[7:0]);
    bytes.push_back(seq[15:8]);
    for (int i = 0; i < 4; i++) bytes.push_back(byte_t'(len >> (8 * i)));
    bytes.push_back(tok);
    if (tok == cfg_token && len <= len_limit()) begin
      for (int i = 0; i < len; i++) begin
        bytes.push_back(($urandom_range(7) == 0) ? cfg_start : byte_t'($urandom_range(255)));
      end
      c = CRC_INIT;
      foreach (bytes[i]) c = crc_next(c, bytes[i]);
      if (bad_crc) c = c ^ crc_t'($urandom_range(1, 65535));
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
    end
    n = (cut < 0 || cut > bytes.size()) ? bytes.size() : cut;
    for (int i = 0; i < n; i++) send_byte(bytes[i]);
    frame_bytes += n;
  endtask

  task automatic test_default_frames();
    send_frame(16'h0000, 32'd0, cfg_token, 1'b0, -1);
    send_frame(16'hFFFF, 32'd3, cfg_token, 1'b0, -1);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_header_faults();
    send_frame(16'h1234, 32'd2, cfg_token ^ 8'h01, 1'b0, -1);
    send_frame(16'h8001, len_limit() + 1, cfg_token, 1'b0, -1);
    send_frame(16'h00FF, 32'hFFFF_FFFF, cfg_token ^ 8'h80, 1'b0, -1);
    send_frame(16'h7FFE, 32'h0001_0000, cfg_token, 1'b0, -1);
  endtask

  task automatic test_crc_fault();
    send_frame(16'h5A5A, 32'd2, cfg_token, 1'b1, -1);
    send_frame(16'hA5A5, 32'd0, cfg_token, 1'b1, -1);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_START_BYTE, 10'h300);
    write_reg(REG_TOKEN_BYTE, 10'h3FF);
    write_reg(REG_MAX_LEN, 10'd0);
    write_reg(REG_SPARE, 10'h3FF);
    send_frame(16'h0000, 32'd0, cfg_token, 1'b0, -1);
    send_frame(16'h0000, 32'd1, cfg_token, 1'b0, -1);
    write_reg(REG_START_BYTE, 10'h0FF);
    write_reg(REG_TOKEN_BYTE, 10'h100);
    write_reg(REG_MAX_LEN, 10'd511);
    send_frame({8'hFF, 8'hFF}, 32'd5, cfg_token, 1'b0, -1);
    send_frame(16'h0100, 32'd511, cfg_token ^ 8'h40, 1'b0, -1);
  endtask

  task automatic test_long_body();
    write_reg(REG_MAX_LEN, 10'd1023);
    send_frame(16'hBEEF, 32'd300, cfg_token, 1'b0, -1);
    send_frame(16'hBEF0, 32'd513, cfg_token, 1'b0, -1);
    write_reg(REG_MAX_LEN, 10'd600);
    send_frame(16'hBEF1, 32'd520, cfg_token, 1'b0, -1);
  endtask

  task automatic test_random_traffic();
    int          sel;
    int          quota;
    logic [31:0] lim;
    logic [31:0] good_len;
    logic [31:0] bad_len;
    logic [15:0] seq;
    quota = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_START_BYTE, 10'($urandom_range(1023)));
      write_reg(REG_TOKEN_BYTE, 10'($urandom_range(1023)));
      case ($urandom_range(2))
        0:       write_reg(REG_MAX_LEN, 10'($urandom_range(16)));
        1:       write_reg(REG_MAX_LEN, 10'd512);
        default: write_reg(REG_MAX_LEN, 10'($urandom_range(1023)));
      endcase
      no_idle = (ph == 2);
      quota = frame_bytes + ((ph == 2) ? 80 : 15);
      lim = len_limit();
      while (frame_bytes < quota) begin
        good_len = $urandom_range((lim < 20) ? lim : 20);
        bad_len = $urandom_range(1) ? (lim + 1 + $urandom_range(8)) : {1'b1, 31'($urandom)};
        seq = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 60) begin
          send_frame(seq, good_len, cfg_token, 1'b0, -1);
        end else if (sel < 70) begin
          send_frame(seq, good_len, cfg_token, 1'b1, -1);
        end else if (sel < 78) begin
          send_frame(seq, $urandom_range(1) ? good_len : bad_len,
                     cfg_token ^ byte_t'($urandom_range(1, 255)), 1'b0, -1);
        end else if (sel < 86) begin
          send_frame(seq, bad_len, cfg_token, 1'b0, -1);
        end else if (sel < 93) begin
          repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(255)));
        end else begin
          send_frame(seq, good_len, cfg_token, 1'b0, $urandom_range(1, 9 + good_len));
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_default_frames();
    test_header_faults();
    test_crc_fault();
    test_register_extremes();
    test_long_body();
    test_random_traffic();
    wait_idle();
    if (pending_results.size() != 0) begin
      report_mismatch("result beats still outstanding at the end");
    end
    if (mismatches == 0) begin
      $display("PASS serial_frame_deframer_crc16");
    end else begin
      $display("FAIL serial_frame_deframer_crc16");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_crc16.sv
hw/rtl/serial_frame_deframer_crc16.sv
tb/serial_frame_deframer_crc16_tb.sv
